FILE: design/spq_pkg.sv
package spq_pkg;

    // Default sizes
    localparam int DEF_NUM_QUEUES  = 8;
    localparam int DEF_QUEUE_DEPTH = 64;

    // Field widths
    localparam int FUNC_W   = 1;
    localparam int RANK_W   = 16;
    localparam int ID_W     = 16;
    localparam int QIDX_W   = 3;
    localparam int LIMIT_W  = 7;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Register indexes (word address bits of paddr)
    localparam logic [PADDR_W-3:0] REG_QUEUE_LIMIT = 1'b0;

    localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 7'd64;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_ENQ = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ = 1'b1;

    // One stored packet
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   packet_id;
    } entry_t;

endpackage

FILE: design/spq_store.sv
module spq_store #(
    parameter int NUM_QUEUES  = spq_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [$clog2(NUM_QUEUES*QUEUE_DEPTH)-1:0]   wr_addr,
    input  spq_pkg::entry_t                             wr_data,
    input  logic                                        rd_en,
    input  logic [$clog2(NUM_QUEUES*QUEUE_DEPTH)-1:0]   rd_addr,
    output spq_pkg::entry_t                             rd_data
);
    import spq_pkg::*;

    localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/spq_bound_map.sv
module spq_bound_map #(
    parameter int NUM_QUEUES = spq_pkg::DEF_NUM_QUEUES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [spq_pkg::RANK_W-1:0]      rank,
    input  logic                            commit,
    output logic                            found,
    output logic [$clog2(NUM_QUEUES)-1:0]   target
);
    import spq_pkg::*;

    localparam int QW = $clog2(NUM_QUEUES);

    logic [RANK_W-1:0]     bound_reg  [NUM_QUEUES];
    logic [RANK_W-1:0]     bound_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] fits;
    logic [RANK_W-1:0]     cost;

    // Compare rank against every bound, pick the lowest-priority queue that fits
    always_comb
    begin
        target = '0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            fits[i] = (rank >= bound_reg[i]);
            if (fits[i])
            begin
                target = QW'(i);
            end
        end
        found = |fits;
    end

    // Push-up raises the chosen bound; push-down shifts all bounds down by the cost
    always_comb
    begin
        cost = bound_reg[0] - rank;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            bound_next[i] = bound_reg[i];
        end
        if (commit)
        begin
            if (found)
            begin
                bound_next[target] = rank;
            end
            else
            begin
                bound_next[0] = rank;
                for (int i = 1; i < NUM_QUEUES; i++)
                begin
                    bound_next[i] = (bound_reg[i] > cost) ? bound_reg[i] - cost : '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                bound_reg[i] <= '0;
            end
        end
        else
        begin
            bound_reg <= bound_next;
        end
    end

endmodule

FILE: design/sp_pifo_rank_scheduler_top.sv
// Strict-priority queue mapper with per-queue rank bounds. Each request (enqueue or
// dequeue) is one input transaction and yields exactly one result transaction, which
// appears in the output register on the cycle after acceptance. The block accepts one
// transaction per clock: all bounds are compared in parallel, queue pointers and counts
// live in flip-flops, and packets sit in a store of NUM_QUEUES*QUEUE_DEPTH entries with
// one write port and a registered read port, so a dequeue's packet comes out of the store
// read register together with its result. Input stalls only while a finished result is
// held by a stalled output. The store needs no clearing pass after reset.
module sp_pifo_rank_scheduler_top #(
    parameter int NUM_QUEUES  = spq_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spq_pkg::PADDR_W-1:0]         paddr,
    input  logic [spq_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [spq_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // Requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spq_pkg::FUNC_W-1:0]          func,
    input  logic [spq_pkg::RANK_W-1:0]          rank,
    input  logic [spq_pkg::ID_W-1:0]            packet_id,
    // Results
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic                                accepted,
    output logic                                dropped,
    output logic [spq_pkg::QIDX_W-1:0]          queue_index,
    output logic                                out_valid,
    output logic                                all_empty,
    output logic [spq_pkg::ID_W-1:0]            out_packet_id,
    output logic [spq_pkg::RANK_W-1:0]          out_rank
);
    import spq_pkg::*;

    localparam int QW   = $clog2(NUM_QUEUES);
    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int AW   = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [PW:0]     DEPTH_P   = (PW + 1)'(QUEUE_DEPTH);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(QUEUE_DEPTH);

    // Configuration state
    logic [LIMIT_W-1:0] queue_limit_reg, queue_limit_next;
    logic               cfg_write;
    logic               cfg_hit;

    // Queue state
    logic [PW-1:0] head_reg  [NUM_QUEUES];
    logic [PW-1:0] head_next [NUM_QUEUES];
    logic [PW-1:0] tail_reg  [NUM_QUEUES];
    logic [PW-1:0] tail_next [NUM_QUEUES];
    logic [CW-1:0] count_reg  [NUM_QUEUES];
    logic [CW-1:0] count_next [NUM_QUEUES];

    // Result register
    logic              res_valid_reg, res_valid_next;
    logic              accepted_reg, accepted_next;
    logic              dropped_reg, dropped_next;
    logic [QIDX_W-1:0] qidx_reg, qidx_next;
    logic              hit_reg, hit_next;
    logic              empty_reg, empty_next;

    // Request decode
    logic                  in_accept;
    logic                  is_deq;
    logic [CMPW-1:0]       limit_eff;
    logic                  enq_found;
    logic [QW-1:0]         enq_target;
    logic                  enq_full;
    logic                  enq_store;
    logic [NUM_QUEUES-1:0] nonempty;
    logic                  deq_hit;
    logic [QW-1:0]         deq_sel;
    logic                  deq_pop;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    entry_t                wr_data;
    entry_t                rd_data;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        logic [PW:0] inc;
        inc = {1'b0, p} + 1'b1;
        return (inc >= DEPTH_P) ? '0 : inc[PW-1:0];
    endfunction

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_hit   = (paddr[PADDR_W-1:2] == REG_QUEUE_LIMIT);
    assign prdata    = cfg_hit ? APB_DATA_W'(queue_limit_reg) : '0;

    always_comb
    begin
        queue_limit_next = queue_limit_reg;
        if (cfg_write && cfg_hit)
        begin
            queue_limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    // Handshake: hold input while the result register is stalled
    assign in_stall  = res_valid_reg & res_stall;
    assign in_accept = in_valid & ~in_stall;
    assign is_deq    = (func == FUNC_DEQ);

    // Bound compare and update
    spq_bound_map #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_bound_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .rank   (rank),
        .commit (enq_store),
        .found  (enq_found),
        .target (enq_target)
    );

    // Enqueue admission against the effective limit
    always_comb
    begin
        limit_eff = (CMPW'(queue_limit_reg) > DEPTH_CMP) ? DEPTH_CMP : CMPW'(queue_limit_reg);
        enq_full  = (CMPW'(count_reg[enq_target]) >= limit_eff);
        enq_store = in_accept & ~is_deq & ~enq_full;
    end

    // Dequeue selection: highest-priority non-empty queue
    always_comb
    begin
        deq_sel = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            nonempty[i] = (count_reg[i] != '0);
            if (nonempty[i])
            begin
                deq_sel = QW'(i);
            end
        end
        deq_hit = |nonempty;
        deq_pop = in_accept & is_deq & deq_hit;
    end

    // Store addressing
    assign wr_addr           = AW'(enq_target) * AW'(QUEUE_DEPTH) + AW'(tail_reg[enq_target]);
    assign rd_addr           = AW'(deq_sel) * AW'(QUEUE_DEPTH) + AW'(head_reg[deq_sel]);
    assign wr_data.rank      = rank;
    assign wr_data.packet_id = packet_id;

    spq_store #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (enq_store),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (deq_pop),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Advance pointers and counts
    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        if (enq_store)
        begin
            tail_next[enq_target]  = ring_next(tail_reg[enq_target]);
            count_next[enq_target] = count_reg[enq_target] + 1'b1;
        end
        if (deq_pop)
        begin
            head_next[deq_sel]  = ring_next(head_reg[deq_sel]);
            count_next[deq_sel] = count_reg[deq_sel] - 1'b1;
        end
    end

    // Load the result register on accept, drop it once taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        accepted_next  = accepted_reg;
        dropped_next   = dropped_reg;
        qidx_next      = qidx_reg;
        hit_next       = hit_reg;
        empty_next     = empty_reg;
        if (in_accept)
        begin
            res_valid_next = 1'b1;
            accepted_next  = enq_store;
            dropped_next   = ~is_deq & enq_full;
            qidx_next      = is_deq ? QIDX_W'(deq_sel) : QIDX_W'(enq_target);
            hit_next       = deq_pop;
            empty_next     = is_deq & ~deq_hit;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= QUEUE_LIMIT_RESET;
            res_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            queue_limit_reg <= queue_limit_next;
            res_valid_reg   <= res_valid_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        dropped_reg  <= dropped_next;
        qidx_reg     <= qidx_next;
        hit_reg      <= hit_next;
        empty_reg    <= empty_next;
    end

    // Drive result ports
    assign res_valid     = res_valid_reg;
    assign accepted      = accepted_reg;
    assign dropped       = dropped_reg;
    assign queue_index   = qidx_reg;
    assign out_valid     = hit_reg;
    assign all_empty     = empty_reg;
    assign out_packet_id = hit_reg ? rd_data.packet_id : '0;
    assign out_rank      = hit_reg ? rd_data.rank : '0;

`ifndef SYNTH
    // A stored packet leaves its queue non-empty
    a_store_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        enq_store |=> count_reg[$past(enq_target)] != '0)
        else $error("queue empty after a stored enqueue");

    // The store is never written into a queue already at full depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        enq_store |-> count_reg[enq_target] < CW'(QUEUE_DEPTH))
        else $error("enqueue stored into a full queue");

    // A new result only follows an accepted request
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(in_accept))
        else $error("result appeared without an accepted request");
`endif

endmodule
